>>> design/markov_step_sampler_unit_assert.svh
// Assertion macros for the Markov step sampler checker.
`ifndef MARKOV_STEP_SAMPLER_UNIT_ASSERT_SVH
`define MARKOV_STEP_SAMPLER_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MSU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MSU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/msu_pkg.sv
// Shared types, constants, microprogram and helpers of the Markov step sampler.
package msu_pkg;

  // Default sizes
  localparam int N_STATES_DEF  = 16;
  localparam int N_ACTIONS_DEF = 4;
  localparam int DATA_W        = 16;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_STATES_IN_USE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_LIMIT    = 1'b1;
  localparam logic [4:0]  STATES_IN_USE_RST = 5'd16;

  // Operation codes carried on s_tuser
  localparam int OP_W = 3;
  localparam logic [OP_W-1:0] OP_STEP     = 3'd0;
  localparam logic [OP_W-1:0] OP_RESET    = 3'd1;
  localparam logic [OP_W-1:0] OP_WR_TRANS = 3'd2;
  localparam logic [OP_W-1:0] OP_WR_MEANS = 3'd3;
  localparam logic [OP_W-1:0] OP_WR_START = 3'd4;

  // Request tdata layout
  localparam int S_TDATA_W   = 144;
  localparam int ACT_LSB     = 0;
  localparam int FROM_LSB    = 2;
  localparam int TO_LSB      = 6;
  localparam int PROB_LSB    = 10;
  localparam int MREW_LSB    = 26;
  localparam int MCOST_LSB   = 42;
  localparam int MSEC_LSB    = 58;
  localparam int DRAW_LSB    = 74;
  localparam int NREW_LSB    = 90;
  localparam int NCOST_LSB   = 106;
  localparam int NSEC_LSB    = 122;
  localparam int S_USED_W    = 138;

  // Result tdata layout
  localparam int M_TDATA_W   = 72;
  localparam int OSTATE_LSB  = 0;
  localparam int OREW_LSB    = 4;
  localparam int OCOST_LSB   = 20;
  localparam int OSEC_LSB    = 36;
  localparam int OSTEPS_LSB  = 52;
  localparam int M_USED_W    = 68;

  // Microprogram addresses
  localparam int UPC_W = 4;
  localparam logic [UPC_W-1:0] UPC_RST_INIT  = 4'd0;
  localparam logic [UPC_W-1:0] UPC_STEP_PAIR = 4'd1;
  localparam logic [UPC_W-1:0] UPC_STEP_BASE = 4'd2;
  localparam logic [UPC_W-1:0] UPC_WALK      = 4'd3;
  localparam logic [UPC_W-1:0] UPC_FINISH    = 4'd4;
  localparam logic [UPC_W-1:0] UPC_FETCH     = 4'd5;
  localparam logic [UPC_W-1:0] UPC_DISPATCH  = 4'd6;
  localparam logic [UPC_W-1:0] UPC_WR_TRANS  = 4'd7;
  localparam logic [UPC_W-1:0] UPC_WR_MEANS  = 4'd8;
  localparam logic [UPC_W-1:0] UPC_WR_START  = 4'd9;

  // Sequencing conditions: taken jumps go to target (dispatch decodes the operation), otherwise fall through
  typedef enum logic [2:0] {
    COND_NEXT,
    COND_JUMP,
    COND_NO_REQ,
    COND_WALK,
    COND_OUT_BUSY,
    COND_DISPATCH
  } cond_t;

  // One control word
  typedef struct packed {
    logic             in_ready;
    logic             walk_clear;
    logic             walk_run;
    logic             load_pair;
    logic             load_base;
    logic             means_re;
    logic             tram_we;
    logic             mram_we;
    logic             sram_we;
    logic             finish;
    cond_t            cond;
    logic [UPC_W-1:0] target;
  } ctrl_t;

  // Datapath status seen by the sequencer
  typedef struct packed {
    logic            in_valid;
    logic            walk_busy;
    logic            out_busy;
    logic [OP_W-1:0] op;
  } status_t;

  // Microprogram store
  function automatic ctrl_t rom_word(input logic [UPC_W-1:0] upc);
    ctrl_t w;
    w = '0;
    w.cond = COND_NEXT;
    w.target = UPC_FETCH;
    unique case (upc)
      UPC_RST_INIT: begin
        w.walk_clear = 1'b1;
        w.cond = COND_JUMP;
        w.target = UPC_WALK;
      end
      UPC_STEP_PAIR: begin
        w.load_pair = 1'b1;
      end
      UPC_STEP_BASE: begin
        w.load_base = 1'b1;
        w.means_re = 1'b1;
        w.walk_clear = 1'b1;
      end
      UPC_WALK: begin
        w.walk_run = 1'b1;
        w.cond = COND_WALK;
        w.target = UPC_WALK;
      end
      UPC_FINISH: begin
        w.finish = 1'b1;
        w.cond = COND_OUT_BUSY;
        w.target = UPC_FINISH;
      end
      UPC_FETCH: begin
        w.in_ready = 1'b1;
        w.cond = COND_NO_REQ;
        w.target = UPC_FETCH;
      end
      UPC_DISPATCH: begin
        w.cond = COND_DISPATCH;
      end
      UPC_WR_TRANS: begin
        w.tram_we = 1'b1;
        w.cond = COND_JUMP;
      end
      UPC_WR_MEANS: begin
        w.mram_we = 1'b1;
        w.cond = COND_JUMP;
      end
      UPC_WR_START: begin
        w.sram_we = 1'b1;
        w.cond = COND_JUMP;
      end
      default: begin
        w.cond = COND_JUMP;
      end
    endcase
    return w;
  endfunction

  // Signed 16-bit add, saturating
  function automatic logic [DATA_W-1:0] sat_add(input logic [DATA_W-1:0] a,
                                                input logic [DATA_W-1:0] b);
    logic [DATA_W:0] s;
    s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
    if (s[DATA_W] != s[DATA_W-1]) begin
      sat_add = s[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      sat_add = s[DATA_W-1:0];
    end
  endfunction

endpackage

>>> design/msu_ram.sv
// Generic single-write, single-read RAM with registered read data.
module msu_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, held when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> design/msu_seq.sv
// Microprogram sequencer: step counter, control store and conditional jumps.
module msu_seq import msu_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  status_t status,
  output ctrl_t   ctrl
);

  logic [UPC_W-1:0] upc;
  logic [UPC_W-1:0] upc_next;
  logic [UPC_W-1:0] upc_inc;

  assign ctrl    = rom_word(upc);
  assign upc_inc = upc + UPC_W'(1);

  // Pick the next control word
  always_comb begin
    upc_next = upc_inc;
    unique case (ctrl.cond)
      COND_NEXT:     upc_next = upc_inc;
      COND_JUMP:     upc_next = ctrl.target;
      COND_NO_REQ:   upc_next = status.in_valid ? upc_inc : ctrl.target;
      COND_WALK:     upc_next = status.walk_busy ? ctrl.target : upc_inc;
      COND_OUT_BUSY: upc_next = status.out_busy ? ctrl.target : upc_inc;
      COND_DISPATCH: begin
        unique case (status.op)
          OP_STEP:     upc_next = UPC_STEP_PAIR;
          OP_RESET:    upc_next = UPC_RST_INIT;
          OP_WR_TRANS: upc_next = UPC_WR_TRANS;
          OP_WR_MEANS: upc_next = UPC_WR_MEANS;
          OP_WR_START: upc_next = UPC_WR_START;
          default:     upc_next = UPC_FETCH;
        endcase
      end
    endcase
  end

  // Advance the step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= UPC_FETCH;
    end else begin
      upc <= upc_next;
    end
  end

endmodule

>>> design/msu_walk.sv
// Inverse-CDF walk: one probability entry read and accumulated per cycle.
module msu_walk import msu_pkg::*; #(
  parameter int N_STATES = N_STATES_DEF,
  localparam int SW = $clog2(N_STATES),
  localparam int SUMW = DATA_W + SW
) (
  input  logic              clk,
  input  logic              rst,
  input  ctrl_t             ctrl,
  input  logic [SW:0]       lim,
  input  logic [DATA_W-1:0] draw,
  input  logic [DATA_W-1:0] rdata,
  output logic              rd_en,
  output logic [SW-1:0]     rd_idx,
  output logic              busy,
  output logic [SW-1:0]     result
);

  logic [SW:0]     idx;
  logic            pend;
  logic            found;
  logic [SW-1:0]   pend_idx;
  logic [SUMW-1:0] sum;
  logic [SUMW-1:0] sum_next;
  logic            more;

  assign more     = (idx < lim) && !found;
  assign rd_en    = ctrl.walk_run && more;
  assign rd_idx   = idx[SW-1:0];
  assign busy     = pend || more;
  assign sum_next = sum + SUMW'(rdata);

  // Issue reads and track which entry is in flight
  always_ff @(posedge clk) begin
    if (rst) begin
      idx   <= '0;
      pend  <= 1'b0;
      found <= 1'b0;
    end else if (ctrl.walk_clear) begin
      idx   <= '0;
      pend  <= 1'b0;
      found <= 1'b0;
    end else if (ctrl.walk_run) begin
      idx  <= idx + (SW+1)'(more);
      pend <= more;
      if (pend && !found && (SUMW'(draw) <= sum_next)) begin
        found <= 1'b1;
      end
    end
  end

  // Accumulate the running sum and latch the first hit
  always_ff @(posedge clk) begin
    if (ctrl.walk_clear) begin
      sum    <= '0;
      result <= '0;
    end else if (ctrl.walk_run) begin
      pend_idx <= idx[SW-1:0];
      if (pend && !found) begin
        sum <= sum_next;
        if (SUMW'(draw) <= sum_next) begin
          result <= pend_idx;
        end
      end
    end
  end

endmodule

>>> design/markov_step_sampler_unit.sv
// Markov step sampler: top level with tables, request latch and result register.
//
// Requests arrive on s_tvalid/s_tready/s_tdata with the operation on s_tuser:
// step, reset, or a write to the transition, means or start-probability tables.
// Only step and reset requests give a result, on m_tvalid/m_tready/m_tdata,
// with the truncation flag on m_tlast. Configuration is a plain write port
// (cfg_we, cfg_index, cfg_data) used while the block is idle.
// A step or reset walks n = min(states_in_use, N_STATES) probability
// entries through one RAM read port, one entry per cycle, and the walk
// loop can end sooner once the draw is reached. A step first forms the
// state-action pair and then the row base before its walk; a reset clears
// the walk and starts it directly, and a table write goes straight back
// to fetching the next request.
// One request is in flight at a time; the next is taken while a result waits
// in the output register, and the block holds in its last step only when a
// new result is ready and the previous one is still untaken.
// Reset clears the current state, the step counter, the configuration
// (states_in_use 16, step_limit 0) and the output valid; tables keep no
// defined contents until written.
module markov_step_sampler_unit import msu_pkg::*; #(
  parameter int N_STATES  = N_STATES_DEF,
  parameter int N_ACTIONS = N_ACTIONS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // action, from_state, to_state, probability, reward mean, cost mean,
  // secondary mean, uniform_draw, reward_noise, cost_noise, secondary_noise, zero pad
  input  logic [S_TDATA_W-1:0]  s_tdata,
  // operation
  input  logic [OP_W-1:0]       s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // observed_state, reward_out, cost_out, secondary_out, steps_taken, zero pad
  output logic [M_TDATA_W-1:0]  m_tdata,
  // truncated_flag
  output logic                  m_tlast
);

  localparam int SW     = $clog2(N_STATES);
  localparam int PAIRS  = N_STATES * N_ACTIONS;
  localparam int PW     = $clog2(PAIRS);
  localparam int TDEPTH = PAIRS * N_STATES;
  localparam int TW     = $clog2(TDEPTH);
  localparam int MW     = 3 * DATA_W;

  ctrl_t   ctrl;
  status_t status;

  // Configuration and architectural state
  logic [4:0]        states_in_use;
  logic [DATA_W-1:0] step_limit;
  logic [SW-1:0]     cur_state;
  logic [DATA_W-1:0] steps_done;

  // Latched request
  logic [S_TDATA_W-1:0] item;
  logic [OP_W-1:0]      item_op;

  logic [1:0]        act;
  logic [3:0]        from_st;
  logic [3:0]        to_st;
  logic [DATA_W-1:0] prob;
  logic [DATA_W-1:0] draw;
  logic [1:0]        act_sat;

  logic [PW-1:0] pair;
  logic [TW-1:0] base;

  logic          t_ok;
  logic          m_ok;
  logic          s_ok;
  logic [TW-1:0] tram_waddr;
  logic [PW-1:0] mram_waddr;
  logic [SW-1:0] sram_waddr;

  logic              src_start;
  logic [SW:0]       lim;
  logic              walk_rd_en;
  logic [SW-1:0]     walk_rd_idx;
  logic              walk_busy;
  logic [SW-1:0]     walk_result;
  logic [DATA_W-1:0] tram_q;
  logic [DATA_W-1:0] sram_q;
  logic [MW-1:0]     mram_q;
  logic [DATA_W-1:0] walk_data;

  logic                 out_busy;
  logic                 finish_go;
  logic [DATA_W-1:0]    cnt_next;
  logic [M_TDATA_W-1:0] payload;
  logic                 payload_last;

  // Unpack the latched request
  assign act     = item[ACT_LSB +: 2];
  assign from_st = item[FROM_LSB +: 4];
  assign to_st   = item[TO_LSB +: 4];
  assign prob    = item[PROB_LSB +: DATA_W];
  assign draw    = item[DRAW_LSB +: DATA_W];

  assign s_tready = ctrl.in_ready;
  assign out_busy = m_tvalid && !m_tready;

  assign status.in_valid  = s_tvalid;
  assign status.walk_busy = walk_busy;
  assign status.out_busy  = out_busy;
  assign status.op        = item_op;

  msu_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  // Take configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      states_in_use <= STATES_IN_USE_RST;
      step_limit    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_STATES_IN_USE: states_in_use <= cfg_data[4:0];
        CFG_STEP_LIMIT:    step_limit    <= cfg_data;
      endcase
    end
  end

  // Latch an accepted request
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item    <= s_tdata;
      item_op <= s_tuser;
    end
  end

  // Table write addresses, dropped when out of range
  assign t_ok = (32'(from_st) < N_STATES) && (32'(act) < N_ACTIONS) &&
                (32'(to_st) < N_STATES);
  assign m_ok = (32'(from_st) < N_STATES) && (32'(act) < N_ACTIONS);
  assign s_ok = (32'(to_st) < N_STATES);
  assign tram_waddr = TW'((32'(from_st) * N_ACTIONS + 32'(act)) * N_STATES
                          + 32'(to_st));
  assign mram_waddr = PW'(32'(from_st) * N_ACTIONS + 32'(act));
  assign sram_waddr = SW'(to_st);

  // Row address of a step: clamp the action, then form pair and row base
  assign act_sat = (32'(act) >= N_ACTIONS) ? 2'(N_ACTIONS - 1) : act;

  always_ff @(posedge clk) begin
    if (ctrl.load_pair) begin
      pair <= PW'(32'(cur_state) * N_ACTIONS + 32'(act_sat));
    end
    if (ctrl.load_base) begin
      base <= TW'(32'(pair) * N_STATES);
    end
  end

  // Tables
  msu_ram #(.WIDTH(DATA_W), .DEPTH(TDEPTH)) u_tram (
    .clk   (clk),
    .we    (ctrl.tram_we && t_ok),
    .waddr (tram_waddr),
    .wdata (prob),
    .re    (walk_rd_en && !src_start),
    .raddr (base + TW'(walk_rd_idx)),
    .rdata (tram_q)
  );

  msu_ram #(.WIDTH(MW), .DEPTH(PAIRS)) u_mram (
    .clk   (clk),
    .we    (ctrl.mram_we && m_ok),
    .waddr (mram_waddr),
    .wdata (item[MREW_LSB +: MW]),
    .re    (ctrl.means_re),
    .raddr (pair),
    .rdata (mram_q)
  );

  msu_ram #(.WIDTH(DATA_W), .DEPTH(N_STATES)) u_sram (
    .clk   (clk),
    .we    (ctrl.sram_we && s_ok),
    .waddr (sram_waddr),
    .wdata (prob),
    .re    (walk_rd_en && src_start),
    .raddr (walk_rd_idx),
    .rdata (sram_q)
  );

  // Walk over the start row for a reset, the transition row for a step
  assign src_start = (item_op == OP_RESET);
  assign walk_data = src_start ? sram_q : tram_q;
  assign lim = (32'(states_in_use) > N_STATES) ? (SW+1)'(N_STATES)
                                               : (SW+1)'(states_in_use);

  msu_walk #(.N_STATES(N_STATES)) u_walk (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .lim    (lim),
    .draw   (draw),
    .rdata  (walk_data),
    .rd_en  (walk_rd_en),
    .rd_idx (walk_rd_idx),
    .busy   (walk_busy),
    .result (walk_result)
  );

  // Finish a request once the output register is free
  assign finish_go = ctrl.finish && !out_busy;
  assign cnt_next  = (steps_done == {DATA_W{1'b1}}) ? steps_done
                                                    : steps_done + DATA_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_state  <= '0;
      steps_done <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (finish_go) begin
        cur_state  <= walk_result;
        steps_done <= src_start ? '0 : cnt_next;
        m_tvalid   <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Form the result payload; a reset result carries zero values
  always_comb begin
    payload = '0;
    payload[OSTATE_LSB +: 4] = 4'(walk_result);
    payload_last = 1'b0;
    if (!src_start) begin
      payload[OREW_LSB +: DATA_W]   = sat_add(mram_q[0 +: DATA_W],
                                              item[NREW_LSB +: DATA_W]);
      payload[OCOST_LSB +: DATA_W]  = sat_add(mram_q[DATA_W +: DATA_W],
                                              item[NCOST_LSB +: DATA_W]);
      payload[OSEC_LSB +: DATA_W]   = sat_add(mram_q[2*DATA_W +: DATA_W],
                                              item[NSEC_LSB +: DATA_W]);
      payload[OSTEPS_LSB +: DATA_W] = cnt_next;
      payload_last = (step_limit != '0) && (cnt_next >= step_limit);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (finish_go) begin
      m_tdata <= payload;
      m_tlast <= payload_last;
    end
  end

endmodule

>>> design/msu_checker.sv
// Port-level checker for the Markov step sampler, bound to the top level.
`include "markov_step_sampler_unit_assert.svh"

module msu_checker import msu_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tvalid,
  input logic                 s_tready,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [M_TDATA_W-1:0] m_tdata,
  input logic                 m_tlast
);

  logic [DATA_W-1:0]  steps;
  logic [M_TDATA_W:0] out_word;
  logic               out_stall;
  logic               reset_clean;

  assign steps       = m_tdata[OSTEPS_LSB +: DATA_W];
  assign out_word    = {m_tlast, m_tdata};
  assign out_stall   = m_tvalid && !m_tready;
  assign reset_clean = (m_tdata[OREW_LSB +: DATA_W] == '0) &&
                       (m_tdata[OCOST_LSB +: DATA_W] == '0) &&
                       (m_tdata[OSEC_LSB +: DATA_W] == '0) && !m_tlast;

  // A stalled result holds
  `MSU_ASSERT_NEXT(a_out_hold, out_stall, m_tvalid && $stable(out_word), "stalled result changed")

  // A request is decoded before the next is taken
  `MSU_ASSERT_NEXT(a_one_request, s_tvalid && s_tready, !s_tready, "request taken back to back")

  // A reset result carries zero values and no truncation
  `MSU_ASSERT_NOW(a_reset_result, m_tvalid && (steps == '0), reset_clean, "reset result not clean")

  // No result straight out of reset
  `MSU_ASSERT_NOW(a_reset_idle, $past(rst), !m_tvalid, "result valid after reset")

endmodule

bind markov_step_sampler_unit msu_checker u_checker (.*);

>>> tb/sv/tb.sv
// Self-checking testbench for the Markov step sampler unit with its own result predictor.
`timescale 1ns / 1ps
module tb;
  import msu_pkg::*;

  localparam int N_ST          = N_STATES_DEF;
  localparam int N_ACT         = N_ACTIONS_DEF;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASE_ITEMS   = 70;
  // Operation codes the block has no use for
  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic [1:0]      act;
    logic [3:0]      from_st;
    logic [3:0]      to_st;
    logic [15:0]     prob;
    logic [15:0]     avg_rew;
    logic [15:0]     avg_cost;
    logic [15:0]     avg_sec;
    logic [15:0]     draw;
    logic [15:0]     noise_rew;
    logic [15:0]     noise_cost;
    logic [15:0]     noise_sec;
  } request_t;

  typedef struct packed {
    logic [3:0]  state;
    logic [15:0] reward;
    logic [15:0] cost;
    logic [15:0] secondary;
    logic [15:0] steps;
    logic        truncated;
  } observation_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [S_TDATA_W-1:0]  s_tdata = '0;
  logic [OP_W-1:0]       s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_tdata;
  logic                  m_tlast;

  // Predicted block state and configuration
  logic [4:0]  walk_states = STATES_IN_USE_RST;
  logic [15:0] trunc_limit = '0;
  logic [3:0]  chain_state = '0;
  logic [15:0] chain_steps = '0;
  logic [15:0] trans_prob [N_ST*N_ACT*N_ST];
  logic [15:0] rew_mean [N_ST*N_ACT];
  logic [15:0] cost_mean [N_ST*N_ACT];
  logic [15:0] sec_mean [N_ST*N_ACT];
  logic [15:0] start_prob [N_ST];

  request_t     request_q [$];
  observation_t observation_q [$];
  request_t     held_req;
  observation_t want;
  int           fail_count = 0;
  int           cycle_count = 0;

  markov_step_sampler_unit dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Inverse CDF over one row: first index whose running sum reaches the draw, else 0
  function automatic logic [3:0] sample_row(input logic [N_ST*16-1:0] row,
                                            input logic [15:0] draw);
    logic [31:0] acc;
    logic [3:0]  hit;
    logic        found;
    int          n;
    acc = '0;
    hit = '0;
    found = 1'b0;
    n = (walk_states > N_ST) ? N_ST : int'(walk_states);
    for (int i = 0; i < n; i++) begin
      acc = acc + 32'(row[i*16 +: 16]);
      if (!found && 32'(draw) <= acc) begin
        hit = 4'(i);
        found = 1'b1;
      end
    end
    return hit;
  endfunction

  // Mean plus noise, clamped to signed 16 bits
  function automatic logic [15:0] noisy_value(input logic [15:0] mean,
                                              input logic [15:0] noise);
    int s;
    s = int'($signed(mean)) + int'($signed(noise));
    if (s > 32767) s = 32767;
    if (s < -32768) s = -32768;
    return 16'(s);
  endfunction

  // Advance the predicted state by one accepted request
  task automatic apply_request(input request_t r);
    logic [N_ST*16-1:0] row;
    observation_t       res;
    int                 pair;
    res = '0;
    pair = int'(r.from_st) * N_ACT + int'(r.act);
    case (r.op)
      OP_WR_TRANS: trans_prob[pair * N_ST + int'(r.to_st)] = r.prob;
      OP_WR_MEANS: begin
        rew_mean[pair] = r.avg_rew;
        cost_mean[pair] = r.avg_cost;
        sec_mean[pair] = r.avg_sec;
      end
      OP_WR_START: start_prob[r.to_st] = r.prob;
      OP_RESET: begin
        for (int i = 0; i < N_ST; i++) row[i*16 +: 16] = start_prob[i];
        chain_state = sample_row(row, r.draw);
        chain_steps = '0;
        res.state = chain_state;
        observation_q.push_back(res);
      end
      OP_STEP: begin
        pair = int'(chain_state) * N_ACT + int'(r.act);
        for (int i = 0; i < N_ST; i++) row[i*16 +: 16] = trans_prob[pair * N_ST + i];
        res.reward = noisy_value(rew_mean[pair], r.noise_rew);
        res.cost = noisy_value(cost_mean[pair], r.noise_cost);
        res.secondary = noisy_value(sec_mean[pair], r.noise_sec);
        chain_state = sample_row(row, r.draw);
        if (chain_steps != 16'hFFFF) chain_steps++;
        res.state = chain_state;
        res.steps = chain_steps;
        res.truncated = (trunc_limit != '0) && (chain_steps >= trunc_limit);
        observation_q.push_back(res);
      end
      default: ;
    endcase
  endtask

  // Random idling, held off in the last quarter of each repeating period of the cycle counter
  function automatic bit idle_now();
    return ((cycle_count % 8000) < 6000) && ($urandom_range(0, 99) < 8);
  endfunction

  task automatic check_field(input string name, input logic [15:0] want_v,
                             input logic [15:0] got_v);
    if (want_v !== got_v) begin
      $error("%s: expected 'h%0h, actual 'h%0h", name, want_v, got_v);
      fail_count++;
    end
  endtask

  // Drive requests from the queue, holding each until the block takes it
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        apply_request(held_req);
      end
      if (!s_tvalid || s_tready) begin
        if (request_q.size() != 0 && !idle_now()) begin
          held_req = request_q.pop_front();
          s_tuser <= held_req.op;
          s_tdata <= {{(S_TDATA_W - S_USED_W){1'b0}}, held_req.noise_sec,
                      held_req.noise_cost, held_req.noise_rew, held_req.draw,
                      held_req.avg_sec, held_req.avg_cost, held_req.avg_rew,
                      held_req.prob, held_req.to_st, held_req.from_st, held_req.act};
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (observation_q.size() == 0) begin
          $error("result with none predicted: observed_state %0d",
                 m_tdata[OSTATE_LSB +: 4]);
          fail_count++;
        end else begin
          want = observation_q.pop_front();
          check_field("observed_state", 16'(want.state), 16'(m_tdata[OSTATE_LSB +: 4]));
          check_field("reward_out", want.reward, m_tdata[OREW_LSB +: 16]);
          check_field("cost_out", want.cost, m_tdata[OCOST_LSB +: 16]);
          check_field("secondary_out", want.secondary, m_tdata[OSEC_LSB +: 16]);
          check_field("steps_taken", want.steps, m_tdata[OSTEPS_LSB +: 16]);
          check_field("truncated_flag", 16'(want.truncated), 16'(m_tlast));
        end
      end
      m_tready <= !idle_now();
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // Probability entry: mostly small so a row of 16 spans the draw range
  function automatic logic [15:0] row_entry();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return 16'h0000;
    if (r < 8) return 16'hFFFF;
    return 16'($urandom_range(0, 8191));
  endfunction

  // Draw scaled to the expected row total, with the extremes now and then
  function automatic logic [15:0] draw_value();
    int r;
    int span;
    r = $urandom_range(0, 99);
    span = ((walk_states > N_ST) ? N_ST : int'(walk_states)) * 4096;
    if (r < 5) return 16'h0000;
    if (r < 10) return 16'hFFFF;
    if (r < 15 || span == 0 || span > 65535) return 16'($urandom);
    return 16'($urandom_range(0, span));
  endfunction

  // Q8.8 value leaning on both saturation edges
  function automatic logic [15:0] q88_value();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'h7FFF;
    if (r == 1) return 16'h8000;
    return 16'($urandom);
  endfunction

  // Request of the given operation with random content elsewhere
  function automatic request_t make_item(input logic [OP_W-1:0] op);
    request_t r;
    r.op = op;
    r.act = 2'($urandom);
    r.from_st = 4'($urandom);
    r.to_st = 4'($urandom);
    r.prob = (op == OP_WR_TRANS || op == OP_WR_START) ? row_entry() : 16'($urandom);
    r.avg_rew = q88_value();
    r.avg_cost = q88_value();
    r.avg_sec = q88_value();
    r.draw = draw_value();
    r.noise_rew = q88_value();
    r.noise_cost = q88_value();
    r.noise_sec = q88_value();
    return r;
  endfunction

  // Wait until the block has gone quiet
  task automatic drain();
    while (request_q.size() != 0 || s_tvalid || observation_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_register(input logic [CFG_IDX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    if (idx == CFG_STATES_IN_USE) walk_states = value[4:0];
    else trunc_limit = value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Idle the block, then load both registers; spare bits above the state count are noise
  task automatic configure(input logic [4:0] states, input logic [15:0] limit);
    drain();
    set_register(CFG_STATES_IN_USE, {11'($urandom), states});
    set_register(CFG_STEP_LIMIT, limit);
  endtask

  // One setting: restart the chain, then a random mix dominated by steps
  task automatic run_phase(input logic [4:0] states, input logic [15:0] limit);
    int r;
    configure(states, limit);
    request_q.push_back(make_item(OP_RESET));
    for (int k = 0; k < PHASE_ITEMS; k++) begin
      r = $urandom_range(0, 99);
      if (r < 68) request_q.push_back(make_item(OP_STEP));
      else if (r < 74) request_q.push_back(make_item(OP_RESET));
      else if (r < 84) request_q.push_back(make_item(OP_WR_TRANS));
      else if (r < 91) request_q.push_back(make_item(OP_WR_MEANS));
      else if (r < 96) request_q.push_back(make_item(OP_WR_START));
      else request_q.push_back(make_item(3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI))));
    end
  endtask

  initial begin
    request_t req;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    configure(5'd16, 16'd0);

    // Fill every table entry so no step or reset reads an unwritten one
    for (int s = 0; s < N_ST; s++) begin
      for (int a = 0; a < N_ACT; a++) begin
        req = make_item(OP_WR_MEANS);
        req.from_st = 4'(s);
        req.act = 2'(a);
        request_q.push_back(req);
        for (int t = 0; t < N_ST; t++) begin
          req = make_item(OP_WR_TRANS);
          req.from_st = 4'(s);
          req.act = 2'(a);
          req.to_st = 4'(t);
          request_q.push_back(req);
        end
      end
    end
    for (int t = 0; t < N_ST; t++) begin
      req = make_item(OP_WR_START);
      req.to_st = 4'(t);
      request_q.push_back(req);
    end

    // Directed: draw extremes on reset and step
    req = make_item(OP_RESET);
    req.draw = 16'h0000;
    request_q.push_back(req);
    req.draw = 16'hFFFF;
    request_q.push_back(req);
    for (int a = 0; a < N_ACT; a++) begin
      req = make_item(OP_STEP);
      req.act = 2'(a);
      request_q.push_back(req);
    end
    req = make_item(OP_STEP);
    req.draw = 16'h0000;
    request_q.push_back(req);
    req.draw = 16'hFFFF;
    request_q.push_back(req);
    // Directed: noise at both extremes
    req = make_item(OP_STEP);
    req.noise_rew = 16'h7FFF;
    req.noise_cost = 16'h7FFF;
    req.noise_sec = 16'h7FFF;
    request_q.push_back(req);
    req = make_item(OP_STEP);
    req.noise_rew = 16'h8000;
    req.noise_cost = 16'h8000;
    req.noise_sec = 16'h8000;
    request_q.push_back(req);
    // Directed: operation codes the block ignores
    for (int c = int'(OP_SPARE_LO); c <= int'(OP_SPARE_HI); c++) begin
      request_q.push_back(make_item(3'(c)));
    end
    // Directed: writes of extreme values
    req = make_item(OP_WR_TRANS);
    req.prob = 16'hFFFF;
    request_q.push_back(req);
    req = make_item(OP_WR_TRANS);
    req.prob = 16'h0000;
    request_q.push_back(req);
    req = make_item(OP_WR_START);
    req.prob = 16'hFFFF;
    request_q.push_back(req);
    req = make_item(OP_WR_START);
    req.prob = 16'h0000;
    request_q.push_back(req);
    req = make_item(OP_WR_MEANS);
    req.avg_rew = 16'h7FFF;
    req.avg_cost = 16'h7FFF;
    req.avg_sec = 16'h7FFF;
    request_q.push_back(req);
    req = make_item(OP_WR_MEANS);
    req.avg_rew = 16'h8000;
    req.avg_cost = 16'h8000;
    req.avg_sec = 16'h8000;
    request_q.push_back(req);

    // Directed: no states in use, then a state count past the table size
    configure(5'd0, 16'd0);
    request_q.push_back(make_item(OP_RESET));
    request_q.push_back(make_item(OP_STEP));
    request_q.push_back(make_item(OP_STEP));
    configure(5'd20, 16'd0);
    request_q.push_back(make_item(OP_RESET));
    request_q.push_back(make_item(OP_STEP));

    // Random phases across several settings
    run_phase(5'd16, 16'd0);
    run_phase(5'd1, 16'd1);
    run_phase(5'd31, 16'hFFFF);
    run_phase(5'($urandom_range(2, 15)), 16'($urandom_range(1, 50)));
    run_phase(5'd0, 16'($urandom_range(1, 50)));
    run_phase(5'd8, 16'd10);
    run_phase(5'($urandom_range(1, 16)), 16'($urandom));
    run_phase(5'd16, 16'd20);

    drain();
    if (fail_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+design
design/msu_pkg.sv
design/msu_ram.sv
design/msu_seq.sv
design/msu_walk.sv
design/markov_step_sampler_unit.sv
design/msu_checker.sv
tb/sv/tb.sv
